// ----- rtl/bqf_pkg.sv -----
// Shared types, constants and helpers for the biquad IIR filter.
package bqf_pkg;

  localparam int CHANNELS        = 8;
  localparam int SAMPLE_BITS     = 24;
  localparam int COEFF_BITS      = 24;
  localparam int COEFF_FRAC_BITS = 20;
  localparam int CH_BITS         = 3;
  localparam int ADDR_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CFG_IDX_BITS    = 3;
  localparam int PROD_BITS       = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_BITS        = PROD_BITS + 3;
  localparam int SHIFT_BITS      = ACC_BITS - COEFF_FRAC_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEFF_BITS-1:0]  coeff_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [CH_BITS-1:0]            chan_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  typedef struct packed {
    coeff_t b0;
    coeff_t b1;
    coeff_t b2;
    coeff_t a1;
    coeff_t a2;
  } coeffs_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_idx_e;

  // Pipeline load strobes and the in-range flag of the last stage
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_s3;
    logic ld_out;
    logic s3_inr;
  } pipe_ctl_t;

  localparam coeff_t  COEFF_B0_RESET = COEFF_BITS'(1) << COEFF_FRAC_BITS;
  localparam acc_t    ROUND_HALF     = ACC_BITS'(1) << (COEFF_FRAC_BITS - 1);
  localparam sample_t SAMPLE_MAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic addr_t ch2addr(chan_t ch);
    logic [CH_BITS+ADDR_BITS-1:0] wide;
    wide = (CH_BITS+ADDR_BITS)'(ch);
    return wide[ADDR_BITS-1:0];
  endfunction

  function automatic logic ch_in_range(chan_t ch);
    return (int'(ch) < CHANNELS);
  endfunction

endpackage

// ----- rtl/bqf_in_if.sv -----
// Input sample channel: valid/ready handshake with channel tag and sample.
interface bqf_in_if import bqf_pkg::*;;
  logic    valid;
  logic    ready;
  chan_t   channel;
  sample_t sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

// ----- rtl/bqf_out_if.sv -----
// Result channel: valid/ready handshake with filtered sample and clip flag.
interface bqf_out_if import bqf_pkg::*;;
  logic    valid;
  logic    ready;
  chan_t   channel_out;
  sample_t sample_out;
  logic    saturated;

  modport source (output valid, output channel_out, output sample_out, output saturated,
                  input ready);
  modport sink   (input valid, input channel_out, input sample_out, input saturated,
                  output ready);
endinterface

// ----- rtl/bqf_hist_mem.sv -----
// Per-channel history memory: one entry per channel, registered read, valid bits.
module bqf_hist_mem import bqf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  re_i,
  input  addr_t raddr_i,
  output hist_t rdata_o,
  input  logic  we_i,
  input  addr_t waddr_i,
  input  hist_t wdata_i
);

  hist_t               mem [CHANNELS];
  hist_t               rd_q;
  logic                rvld_q;
  logic [CHANNELS-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // An entry never written reads as zero history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule

// ----- rtl/bqf_mac.sv -----
// Multiply, accumulate, round and saturate pipeline for one biquad section.
module bqf_mac import bqf_pkg::*; (
  input  logic      clk_i,
  input  pipe_ctl_t ctl_i,
  input  coeffs_t   coeffs_i,
  input  sample_t   sample_i,
  input  hist_t     hist_i,
  output hist_t     wb_o,
  output sample_t   sample_o,
  output logic      saturated_o
);

  // Stage 1
  sample_t s1_x_q;
  // Stage 2
  prod_t   p_b0_q, p_b1_q, p_b2_q, p_a1_q, p_a2_q;
  sample_t s2_x_q, s2_x1_q, s2_y1_q;
  // Stage 3
  acc_t    sum_ff_q, sum_fb_q;
  sample_t s3_x_q, s3_x1_q, s3_y1_q;
  // Output
  sample_t out_y_q;
  logic    out_sat_q;

  acc_t                  acc;
  logic [SHIFT_BITS-1:0] shifted;
  logic [SHIFT_BITS-SAMPLE_BITS:0] upper;
  logic                  ovf;
  sample_t               y;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_s1) begin
      s1_x_q <= sample_i;
    end
    if (ctl_i.ld_s2) begin
      p_b0_q  <= PROD_BITS'(coeffs_i.b0) * PROD_BITS'(s1_x_q);
      p_b1_q  <= PROD_BITS'(coeffs_i.b1) * PROD_BITS'(hist_i.x1);
      p_b2_q  <= PROD_BITS'(coeffs_i.b2) * PROD_BITS'(hist_i.x2);
      p_a1_q  <= PROD_BITS'(coeffs_i.a1) * PROD_BITS'(hist_i.y1);
      p_a2_q  <= PROD_BITS'(coeffs_i.a2) * PROD_BITS'(hist_i.y2);
      s2_x_q  <= s1_x_q;
      s2_x1_q <= hist_i.x1;
      s2_y1_q <= hist_i.y1;
    end
    if (ctl_i.ld_s3) begin
      sum_ff_q <= ACC_BITS'(p_b0_q) + ACC_BITS'(p_b1_q) + ACC_BITS'(p_b2_q);
      sum_fb_q <= ACC_BITS'(p_a1_q) + ACC_BITS'(p_a2_q);
      s3_x_q   <= s2_x_q;
      s3_x1_q  <= s2_x1_q;
      s3_y1_q  <= s2_y1_q;
    end
    if (ctl_i.ld_out) begin
      out_y_q   <= ctl_i.s3_inr ? y : '0;
      out_sat_q <= ctl_i.s3_inr & ovf;
    end
  end

  // Round half up, drop fraction bits, clip to the sample range
  always_comb begin
    acc     = sum_ff_q - sum_fb_q + ROUND_HALF;
    shifted = acc[ACC_BITS-1:COEFF_FRAC_BITS];
    upper   = shifted[SHIFT_BITS-1:SAMPLE_BITS-1];
    ovf     = !((&upper) || (~|upper));
    if (ovf) begin
      y = shifted[SHIFT_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      y = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    wb_o.x1 = s3_x_q;
    wb_o.x2 = s3_x1_q;
    wb_o.y1 = y;
    wb_o.y2 = s3_y1_q;
  end

  assign sample_o    = out_y_q;
  assign saturated_o = out_sat_q;

endmodule

// ----- rtl/biquad_iir_filter.sv -----
// Top level of the multichannel direct form I biquad IIR filter.
//
// Channels: in_i takes one transaction per sample (channel tag plus signed
// sample); out_o returns exactly one transaction per input, in input order,
// carrying the channel, the rounded and clipped sample and a clip flag.
// The user writes coefficients b0, b1, b2, a1, a2 through cfg_we_i/cfg_idx_i/
// cfg_wdata_i only while no transaction is in flight; the block does not check.
// A result passes the stage 1, 2 and 3 registers, then the output register.
// Throughput: one sample per cycle while the output is not stalled and each
// sample's channel differs from those in stages 1 to 3. A sample on a channel
// that is still in stage 1, 2 or 3 waits until that channel's history is
// written back as its result enters the output register; the history memory's
// read-then-write loop sets this limit for back-to-back samples on one channel.
// Reset: coefficients return to b0 = 1.0 and the rest to zero, and all
// channel histories read as zero until written.
// Stall: a result waits in the output register while out_o.ready is low;
// earlier stages keep filling until the pipeline is full, then in_i.ready drops.
module biquad_iir_filter import bqf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COEFF_BITS-1:0]   cfg_wdata_i,
  bqf_in_if.sink                  in_i,
  bqf_out_if.source               out_o
);

  coeffs_t   coeffs_q;
  logic      s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic      s1_v_d, s2_v_d, s3_v_d, out_v_d;
  chan_t     s1_ch_q, s2_ch_q, s3_ch_q, out_ch_q;
  logic      s1_inr_q, s2_inr_q, s3_inr_q;
  logic      accept, out_free, en2, en3, en1, hazard;
  pipe_ctl_t ctl;
  hist_t     hist_rd, hist_wb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeffs_q.b0 <= COEFF_B0_RESET;
      coeffs_q.b1 <= '0;
      coeffs_q.b2 <= '0;
      coeffs_q.a1 <= '0;
      coeffs_q.a2 <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_B0:  coeffs_q.b0 <= cfg_wdata_i;
        CFG_B1:  coeffs_q.b1 <= cfg_wdata_i;
        CFG_B2:  coeffs_q.b2 <= cfg_wdata_i;
        CFG_A1:  coeffs_q.a1 <= cfg_wdata_i;
        CFG_A2:  coeffs_q.a2 <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when the next one is empty or moving
  always_comb begin
    out_free = !out_v_q || out_o.ready;
    en3      = !s3_v_q || out_free;
    en2      = !s2_v_q || en3;
    en1      = !s1_v_q || en2;
    // Hold a sample whose channel is still in flight
    hazard   = (s1_v_q && (s1_ch_q == in_i.channel)) ||
               (s2_v_q && (s2_ch_q == in_i.channel)) ||
               (s3_v_q && (s3_ch_q == in_i.channel));
  end

  assign in_i.ready = en1 && !hazard;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    ctl.ld_s1  = accept;
    ctl.ld_s2  = s1_v_q && en2;
    ctl.ld_s3  = s2_v_q && en3;
    ctl.ld_out = s3_v_q && out_free;
    ctl.s3_inr = s3_inr_q;
  end

  always_comb begin
    s1_v_d  = accept || (s1_v_q && !en2);
    s2_v_d  = ctl.ld_s2 || (s2_v_q && !en3);
    s3_v_d  = ctl.ld_s3 || (s3_v_q && !out_free);
    out_v_d = ctl.ld_out || (out_v_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      s3_v_q  <= s3_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.ld_s1) begin
      s1_ch_q  <= in_i.channel;
      s1_inr_q <= ch_in_range(in_i.channel);
    end
    if (ctl.ld_s2) begin
      s2_ch_q  <= s1_ch_q;
      s2_inr_q <= s1_inr_q;
    end
    if (ctl.ld_s3) begin
      s3_ch_q  <= s2_ch_q;
      s3_inr_q <= s2_inr_q;
    end
    if (ctl.ld_out) begin
      out_ch_q <= s3_ch_q;
    end
  end

  bqf_hist_mem u_hist_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (ch2addr(in_i.channel)),
    .rdata_o (hist_rd),
    .we_i    (ctl.ld_out && s3_inr_q),
    .waddr_i (ch2addr(s3_ch_q)),
    .wdata_i (hist_wb)
  );

  bqf_mac u_mac (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .coeffs_i    (coeffs_q),
    .sample_i    (in_i.sample_in),
    .hist_i      (hist_rd),
    .wb_o        (hist_wb),
    .sample_o    (out_o.sample_out),
    .saturated_o (out_o.saturated)
  );

  assign out_o.valid       = out_v_q;
  assign out_o.channel_out = out_ch_q;

endmodule

// ----- rtl/bqf_checker.sv -----
// Port-level checks for the biquad IIR filter, bound to the top level.
module bqf_checker import bqf_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid,
  input logic    in_ready,
  input chan_t   in_channel,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_sample,
  input logic    out_saturated
);

  logic [2:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_saturated))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> cnt_q != 3'd0)
    else $error("result without pending input");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("more transactions in flight than pipeline stages");

  a_same_ch_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !(in_acc && (in_channel == $past(in_channel))))
    else $error("same channel accepted in consecutive cycles");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_saturated |-> out_sample == SAMPLE_MAX || out_sample == SAMPLE_MIN)
    else $error("clip flag set on an unclipped value");

endmodule

bind biquad_iir_filter bqf_checker u_bqf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .in_channel    (in_i.channel),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_sample    (out_o.sample_out),
  .out_saturated (out_o.saturated)
);

// ----- dv/biquad_checker.sv -----
// Checker for the biquad filter: tracks coefficients and channel history, predicts and compares.
`timescale 1ns / 1ps

module biquad_checker import bqf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COEFF_BITS-1:0]   cfg_wdata_i,
  bqf_in_if                       in_i,
  bqf_out_if                      out_i,
  output int                      errors_o,
  output int                      pending_o
);

  typedef struct packed {
    chan_t   channel;
    sample_t sample;
    logic    clipped;
  } filt_result_t;

  coeffs_t      taps;
  sample_t      x_hist1 [CHANNELS];
  sample_t      x_hist2 [CHANNELS];
  sample_t      y_hist1 [CHANNELS];
  sample_t      y_hist2 [CHANNELS];
  filt_result_t expected_outputs [$];
  filt_result_t want;
  int           mismatches;

  // Run one sample through the channel's section and advance its history.
  function automatic filt_result_t filter_sample(chan_t ch, sample_t x);
    filt_result_t r;
    longint       acc;
    longint       y;
    int           c;
    r.channel = ch;
    r.sample  = '0;
    r.clipped = 1'b0;
    c = int'(ch);
    if (c >= CHANNELS) return r;
    acc = longint'(taps.b0) * longint'(x)
        + longint'(taps.b1) * longint'(x_hist1[c])
        + longint'(taps.b2) * longint'(x_hist2[c])
        - longint'(taps.a1) * longint'(y_hist1[c])
        - longint'(taps.a2) * longint'(y_hist2[c]);
    // round half up, then floor
    acc = acc + (longint'(1) << (COEFF_FRAC_BITS - 1));
    y = acc >>> COEFF_FRAC_BITS;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      r.clipped = 1'b1;
    end
    if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      r.clipped = 1'b1;
    end
    r.sample   = sample_t'(y);
    x_hist2[c] = x_hist1[c];
    x_hist1[c] = x;
    y_hist2[c] = y_hist1[c];
    y_hist1[c] = r.sample;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps.b0 = COEFF_B0_RESET;
      taps.b1 = '0;
      taps.b2 = '0;
      taps.a1 = '0;
      taps.a2 = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        x_hist1[c] = '0;
        x_hist2[c] = '0;
        y_hist1[c] = '0;
        y_hist2[c] = '0;
      end
      expected_outputs.delete();
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        expected_outputs.push_back(filter_sample(in_i.channel, in_i.sample_in));
      end

      if (out_i.valid && out_i.ready) begin
        if (expected_outputs.size() == 0) begin
          mismatches++;
          $error("result on channel %0d with no sample outstanding", out_i.channel_out);
        end else begin
          want = expected_outputs.pop_front();
          if (out_i.channel_out !== want.channel) begin
            mismatches++;
            $error("channel_out: expected %0d, got %0d", want.channel, out_i.channel_out);
          end
          if (out_i.sample_out !== want.sample) begin
            mismatches++;
            $error("sample_out: expected %0d, got %0d", want.sample, out_i.sample_out);
          end
          if (out_i.saturated !== want.clipped) begin
            mismatches++;
            $error("saturated: expected %0b, got %0b", want.clipped, out_i.saturated);
          end
        end
      end

      // writes must land only while idle (the user's rule; nothing here enforces it); unused indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_B0:  taps.b0 = coeff_t'(cfg_wdata_i);
          CFG_B1:  taps.b1 = coeff_t'(cfg_wdata_i);
          CFG_B2:  taps.b2 = coeff_t'(cfg_wdata_i);
          CFG_A1:  taps.a1 = coeff_t'(cfg_wdata_i);
          CFG_A2:  taps.a2 = coeff_t'(cfg_wdata_i);
          default: ;
        endcase
      end

      errors_o  <= mismatches;
      pending_o <= expected_outputs.size();
    end
  end

endmodule

// ----- dv/tb_biquad_iir_filter.sv -----
// Testbench top for the biquad filter: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_biquad_iir_filter import bqf_pkg::*; ;

  localparam int TIMEOUT_NS      = 3_000_000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int ONE_Q           = 1 << COEFF_FRAC_BITS;
  localparam coeff_t COEFF_MAX   = {1'b0, {(COEFF_BITS-1){1'b1}}};
  localparam coeff_t COEFF_MIN   = {1'b1, {(COEFF_BITS-1){1'b0}}};

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [COEFF_BITS-1:0]   cfg_wdata;
  int                      check_errors;
  int                      check_pending;

  bqf_in_if  in_ch ();
  bqf_out_if out_ch ();

  biquad_iir_filter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  biquad_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .errors_o    (check_errors),
    .pending_o   (check_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  function automatic coeff_t mild_coeff(int span);
    return coeff_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coeffs_t pick_taps(int style);
    coeffs_t c;
    c = '0;
    unique case (style)
      0: begin
        c.b0 = mild_coeff(ONE_Q);
        c.b1 = mild_coeff(ONE_Q);
        c.b2 = mild_coeff(ONE_Q);
        c.a1 = mild_coeff(2 * ONE_Q);
        c.a2 = mild_coeff(ONE_Q / 2);
      end
      2: begin
        c.b0 = COEFF_MAX;
        c.b1 = COEFF_MAX;
        c.b2 = COEFF_MAX;
        c.a1 = COEFF_MAX;
        c.a2 = COEFF_MAX;
      end
      3: c.b0 = coeff_t'($urandom);
      4: begin
        c.b0 = COEFF_MIN;
        c.b1 = COEFF_MIN;
        c.b2 = COEFF_MIN;
        c.a1 = COEFF_MIN;
        c.a2 = COEFF_MIN;
      end
      5: begin
        c.b0 = coeff_t'($urandom);
        c.b1 = coeff_t'($urandom);
        c.b2 = coeff_t'($urandom);
        c.a1 = mild_coeff(2 * ONE_Q);
        c.a2 = mild_coeff(ONE_Q);
      end
      default: begin
        c.b0 = coeff_t'($urandom);
        c.b1 = coeff_t'($urandom);
        c.b2 = coeff_t'($urandom);
        c.a1 = coeff_t'($urandom);
        c.a2 = coeff_t'($urandom);
      end
    endcase
    return c;
  endfunction

  function automatic sample_t pick_sample();
    unique case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3, 4, 5: return sample_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Write all coefficients on consecutive edges; optionally poke the unused indexes.
  task automatic program_taps(coeffs_t c, bit poke_unused);
    for (int i = 0; i < 2 ** CFG_IDX_BITS; i++) begin
      if (i > int'(CFG_A2) && !poke_unused) break;
      cfg_we  <= 1'b1;
      cfg_idx <= CFG_IDX_BITS'(i);
      unique case (cfg_idx_e'(i))
        CFG_B0:  cfg_wdata <= c.b0;
        CFG_B1:  cfg_wdata <= c.b1;
        CFG_B2:  cfg_wdata <= c.b2;
        CFG_A1:  cfg_wdata <= c.a1;
        CFG_A2:  cfg_wdata <= c.a2;
        default: cfg_wdata <= COEFF_BITS'($urandom);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Present one sample and hold it until the transaction completes.
  task automatic send_sample(chan_t ch, sample_t s);
    in_ch.valid     <= 1'b1;
    in_ch.channel   <= ch;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Bursts of samples with random gaps; a burst walks, repeats or scatters channels.
  task automatic stream_samples(int count);
    int    sent;
    int    burst;
    int    mode;
    chan_t ch;
    sent = 0;
    ch   = chan_t'($urandom);
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      mode  = $urandom_range(0, 2);
      for (int k = 0; k < burst && sent < count; k++) begin
        unique case (mode)
          0:       ch = chan_t'($urandom);
          2:       ch = ch + 1'b1;
          default: ;
        endcase
        send_sample(ch, pick_sample());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Output stalls: free-running, light, heavy and solid-stall stretches.
  initial begin
    int mode;
    int len;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      len  = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(4, 40);
      repeat (len) begin
        @(posedge clk);
        unique case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= ($urandom_range(0, 2) == 0);
          default: out_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    coeffs_t c;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.channel   <= '0;
    in_ch.sample_in <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: unity gain, extremes pass through untouched.
    send_sample(chan_t'(0), SAMPLE_MAX);
    send_sample(chan_t'(7), SAMPLE_MIN);
    send_sample(chan_t'(1), sample_t'(-1));
    send_sample(chan_t'(2), sample_t'(1));
    send_sample(chan_t'(3), '0);
    send_sample(chan_t'(6), sample_t'(24'h555555));
    send_sample(chan_t'(5), sample_t'(24'h2aaaaa));
    drain_results();

    // Half gain: odd samples land exactly on a rounding tie.
    c    = '0;
    c.b0 = coeff_t'(ONE_Q / 2);
    program_taps(c, 1'b1);
    send_sample(chan_t'(4), sample_t'(1));
    send_sample(chan_t'(4), sample_t'(-1));
    send_sample(chan_t'(4), sample_t'(3));
    send_sample(chan_t'(4), sample_t'(-3));
    drain_results();

    // Alternating extreme coefficients: clip high and low.
    c.b0 = COEFF_MAX;
    c.b1 = COEFF_MIN;
    c.b2 = COEFF_MAX;
    c.a1 = COEFF_MIN;
    c.a2 = COEFF_MAX;
    program_taps(c, 1'b1);
    send_sample(chan_t'(5), SAMPLE_MAX);
    send_sample(chan_t'(5), SAMPLE_MAX);
    send_sample(chan_t'(5), SAMPLE_MIN);
    send_sample(chan_t'(5), SAMPLE_MIN);
    send_sample(chan_t'(5), '0);
    drain_results();

    program_taps(pick_taps(4), 1'b0);
    send_sample(chan_t'(6), SAMPLE_MIN);
    send_sample(chan_t'(6), SAMPLE_MIN);
    send_sample(chan_t'(6), SAMPLE_MAX);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_taps(pick_taps(phase), 1'b0);
      stream_samples(ITEMS_PER_PHASE);
      drain_results();
    end

    if (check_errors == 0 && check_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
